[rtl/core/srpt_pkg.sv]
package srpt_pkg;

	localparam int QDEPTH = 64;
	localparam int CNT_W  = $clog2(QDEPTH + 1);
	localparam int TIME_W = 32;
	localparam int TAG_W  = 16;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

	typedef struct packed {
		logic [TIME_W-1:0] remain;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] size;
		logic [TAG_W-1:0]  tag;
	} job_t;

	// control from the scheduler to the queue row
	typedef struct packed {
		logic ins_en;
		logic pop_en;
		job_t ins_job;
	} queue_ctl_t;

	typedef struct packed {
		job_t             head;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] count_nxt;
	} queue_status_t;

	typedef enum logic {
		ACT_ARRIVE = 1'b0,
		ACT_DONE   = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ERR_OK   = 2'd0,
		ERR_FULL = 2'd1,
		ERR_IDLE = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		START_NONE,
		START_NEW,
		START_HEAD,
		START_CLEAR
	} start_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_COMMIT
	} state_t;

endpackage

[rtl/core/srpt_cell.sv]
module srpt_cell (
	input  logic               clk,
	input  srpt_pkg::queue_ctl_t ctl,
	input  logic               occupied,
	input  logic               ge_prev,
	input  srpt_pkg::job_t     entry_prev,
	input  srpt_pkg::job_t     entry_next,
	output logic               ge,
	output srpt_pkg::job_t     entry
);

	srpt_pkg::job_t entry_q;

	// new job goes in front of this entry (empty slots count as larger)
	assign ge    = !occupied || (ctl.ins_job.remain < entry_q.remain);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (ge_prev) begin
				entry_q <= entry_prev;
			end else if (ge) begin
				entry_q <= ctl.ins_job;
			end
		end else if (ctl.pop_en) begin
			entry_q <= entry_next;
		end
	end

endmodule

[rtl/core/srpt_queue.sv]
module srpt_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  srpt_pkg::queue_ctl_t    ctl,
	output srpt_pkg::queue_status_t status
);

	localparam int N = srpt_pkg::QDEPTH;

	srpt_pkg::job_t              entry [N];
	logic [N-1:0]                ge;
	logic [srpt_pkg::CNT_W-1:0]  count_q;
	logic [srpt_pkg::CNT_W-1:0]  count_nxt;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic           ge_prev;
		srpt_pkg::job_t prev_e;
		srpt_pkg::job_t next_e;

		if (i == 0) begin : g_first
			assign ge_prev = 1'b0;
			assign prev_e  = entry[i];
		end else begin : g_mid
			assign ge_prev = ge[i-1];
			assign prev_e  = entry[i-1];
		end

		if (i == N - 1) begin : g_last
			assign next_e = entry[i];
		end else begin : g_inner
			assign next_e = entry[i+1];
		end

		srpt_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (srpt_pkg::CNT_W'(i) < count_q),
			.ge_prev    (ge_prev),
			.entry_prev (prev_e),
			.entry_next (next_e),
			.ge         (ge[i]),
			.entry      (entry[i])
		);
	end

	always_comb begin
		count_nxt = count_q;
		if (ctl.ins_en) begin
			count_nxt = count_q + 1'b1;
		end else if (ctl.pop_en) begin
			count_nxt = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	assign status.head      = entry[0];
	assign status.count     = count_q;
	assign status.count_nxt = count_nxt;

endmodule

[rtl/core/srpt_preemptive_scheduler.sv]
// Preemptive shortest-remaining-time scheduler.
// Event channel (event_valid/event_stall): action 0 is a job arrival with
// job_size and job_tag, action 1 completes the running job; event_time
// stamps both. Result channel (result_valid/result_stall): one item per
// event with departure stats, the job running afterwards, queue occupancy
// and an error code. Dropped events (queue full, completion while idle)
// still return an item with the error set and leave the state unchanged.
// The evaluate state works out the remaining time and the preemption
// choice, and the commit state shifts the row of queue cells and loads
// the running job. One event is in flight at a time.
// The result register frees the event side: the next event is taken while
// a result waits. If the receiver stalls, the result holds and the next
// event waits in the commit stage, and event_stall stays high.
// Reset clears the running job and the queue count; queue cells need no
// clearing since only occupied cells are ever read.
module srpt_preemptive_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        event_valid,
	output logic        event_stall,
	input  logic        action,
	input  logic [31:0] event_time,
	input  logic [31:0] job_size,
	input  logic [15:0] job_tag,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        departed_valid,
	output logic [15:0] departed_tag,
	output logic [31:0] response_time,
	output logic [31:0] waiting_time,
	output logic        busy_res,
	output logic [15:0] running_tag,
	output logic [31:0] next_finish_time,
	output logic [6:0]  waiting_count,
	output logic [1:0]  error_code
);

	localparam int TW = srpt_pkg::TIME_W;
	localparam int GW = srpt_pkg::TAG_W;

	srpt_pkg::state_t state_q, state_nxt;
	logic ev_accept, commit_fire;

	// event stage
	logic          action_s1;
	logic [TW-1:0] time_s1, size_s1;
	logic [GW-1:0] tag_s1;

	// commit stage
	logic             ins_en_s2, pop_en_s2;
	srpt_pkg::job_t   ins_job_s2;
	srpt_pkg::start_t start_s2;
	logic [TW-1:0]    time_s2, size_s2, resp_s2, dep_size_s2;
	logic [GW-1:0]    tag_s2, dep_tag_s2;
	logic             dep_valid_s2;
	srpt_pkg::err_t   err_s2;

	// running job
	logic          busy_q;
	logic [TW-1:0] finish_q, rsize_q, arrival_q;
	logic [GW-1:0] id_q;

	logic          result_valid_q;

	srpt_pkg::queue_ctl_t    qctl;
	srpt_pkg::queue_status_t qst;

	srpt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (qctl),
		.status (qst)
	);

	// ---------------- control ----------------
	assign commit_fire = (state_q == srpt_pkg::ST_COMMIT) && (!result_valid_q || !result_stall);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			srpt_pkg::ST_IDLE: begin
				if (event_valid) state_nxt = srpt_pkg::ST_EVAL;
			end
			srpt_pkg::ST_EVAL: begin
				state_nxt = srpt_pkg::ST_COMMIT;
			end
			srpt_pkg::ST_COMMIT: begin
				if (commit_fire) begin
					state_nxt = event_valid ? srpt_pkg::ST_EVAL : srpt_pkg::ST_IDLE;
				end
			end
			default: state_nxt = srpt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		event_stall = !((state_q == srpt_pkg::ST_IDLE) || commit_fire);
		qctl.ins_en  = commit_fire && ins_en_s2;
		qctl.pop_en  = commit_fire && pop_en_s2;
		qctl.ins_job = ins_job_s2;
	end

	assign ev_accept = event_valid && !event_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srpt_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_accept) begin
			action_s1 <= action;
			time_s1   <= event_time;
			size_s1   <= job_size;
			tag_s1    <= job_tag;
		end
	end

	// ---------------- evaluate ----------------
	logic [TW-1:0]    rem, resp;
	logic             ins_en_e, pop_en_e, dep_valid_e;
	srpt_pkg::job_t   ins_job_e;
	srpt_pkg::start_t start_e;
	srpt_pkg::err_t   err_e;

	always_comb begin
		rem  = (finish_q >= time_s1) ? finish_q - time_s1 : '0;
		resp = (time_s1 >= arrival_q) ? time_s1 - arrival_q : '0;

		ins_en_e    = 1'b0;
		pop_en_e    = 1'b0;
		dep_valid_e = 1'b0;
		start_e     = srpt_pkg::START_NONE;
		err_e       = srpt_pkg::ERR_OK;
		ins_job_e   = '{remain: size_s1, arrival: time_s1, size: size_s1, tag: tag_s1};

		if (action_s1 == srpt_pkg::ACT_ARRIVE) begin
			priority if (!busy_q) begin
				start_e = srpt_pkg::START_NEW;
			end else if (qst.count == srpt_pkg::CNT_FULL) begin
				err_e = srpt_pkg::ERR_FULL;
			end else if (rem < size_s1) begin
				ins_en_e = 1'b1;
			end else begin
				// preempt: running job goes back with its remainder
				ins_en_e  = 1'b1;
				ins_job_e = '{remain: rem, arrival: arrival_q, size: rsize_q, tag: id_q};
				start_e   = srpt_pkg::START_NEW;
			end
		end else begin
			priority if (!busy_q) begin
				err_e = srpt_pkg::ERR_IDLE;
			end else if (qst.count == '0) begin
				dep_valid_e = 1'b1;
				start_e     = srpt_pkg::START_CLEAR;
			end else begin
				dep_valid_e = 1'b1;
				pop_en_e    = 1'b1;
				start_e     = srpt_pkg::START_HEAD;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == srpt_pkg::ST_EVAL) begin
			ins_job_s2   <= ins_job_e;
			start_s2     <= start_e;
			time_s2      <= time_s1;
			size_s2      <= size_s1;
			tag_s2       <= tag_s1;
			resp_s2      <= dep_valid_e ? resp : '0;
			dep_size_s2  <= dep_valid_e ? rsize_q : '0;
			dep_tag_s2   <= dep_valid_e ? id_q : '0;
			dep_valid_s2 <= dep_valid_e;
			err_s2       <= err_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_en_s2 <= 1'b0;
			pop_en_s2 <= 1'b0;
		end else if (state_q == srpt_pkg::ST_EVAL) begin
			ins_en_s2 <= ins_en_e;
			pop_en_s2 <= pop_en_e;
		end
	end

	// ---------------- commit ----------------
	logic [TW-1:0] start_remain, wait_c, finish_nxt, rsize_nxt, arrival_nxt;
	logic [TW:0]   finish_sum;
	logic [GW-1:0] id_nxt;
	logic          busy_nxt;

	always_comb begin
		start_remain = (start_s2 == srpt_pkg::START_NEW) ? size_s2 : qst.head.remain;
		finish_sum   = {1'b0, time_s2} + {1'b0, start_remain};
		wait_c       = (resp_s2 >= dep_size_s2) ? resp_s2 - dep_size_s2 : '0;

		busy_nxt    = busy_q;
		finish_nxt  = finish_q;
		rsize_nxt   = rsize_q;
		arrival_nxt = arrival_q;
		id_nxt      = id_q;
		unique case (start_s2)
			srpt_pkg::START_NONE: ;
			srpt_pkg::START_NEW: begin
				busy_nxt    = 1'b1;
				finish_nxt  = finish_sum[TW] ? '1 : finish_sum[TW-1:0];
				rsize_nxt   = size_s2;
				arrival_nxt = time_s2;
				id_nxt      = tag_s2;
			end
			srpt_pkg::START_HEAD: begin
				busy_nxt    = 1'b1;
				finish_nxt  = finish_sum[TW] ? '1 : finish_sum[TW-1:0];
				rsize_nxt   = qst.head.size;
				arrival_nxt = qst.head.arrival;
				id_nxt      = qst.head.tag;
			end
			srpt_pkg::START_CLEAR: begin
				busy_nxt    = 1'b0;
				finish_nxt  = '0;
				rsize_nxt   = '0;
				arrival_nxt = '0;
				id_nxt      = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			finish_q  <= '0;
			rsize_q   <= '0;
			arrival_q <= '0;
			id_q      <= '0;
		end else if (commit_fire) begin
			busy_q    <= busy_nxt;
			finish_q  <= finish_nxt;
			rsize_q   <= rsize_nxt;
			arrival_q <= arrival_nxt;
			id_q      <= id_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (commit_fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_fire) begin
			departed_valid   <= dep_valid_s2;
			departed_tag     <= dep_tag_s2;
			response_time    <= resp_s2;
			waiting_time     <= wait_c;
			busy_res         <= busy_nxt;
			running_tag      <= busy_nxt ? id_nxt : '0;
			next_finish_time <= busy_nxt ? finish_nxt : '0;
			waiting_count    <= 7'(qst.count_nxt);
			error_code       <= err_s2;
		end
	end

	assign result_valid = result_valid_q;

endmodule

[tb/sv/srpt_result_checker.sv]
`timescale 1ns / 1ps

module srpt_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        event_valid,
	input  logic        event_stall,
	input  logic        action,
	input  logic [31:0] event_time,
	input  logic [31:0] job_size,
	input  logic [15:0] job_tag,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic        departed_valid,
	input  logic [15:0] departed_tag,
	input  logic [31:0] response_time,
	input  logic [31:0] waiting_time,
	input  logic        busy_res,
	input  logic [15:0] running_tag,
	input  logic [31:0] next_finish_time,
	input  logic [6:0]  waiting_count,
	input  logic [1:0]  error_code,
	output int          fail_count,
	output int          reports_due
);

	localparam int TW = srpt_pkg::TIME_W;
	localparam int GW = srpt_pkg::TAG_W;
	localparam int CW = srpt_pkg::CNT_W;

	typedef struct packed {
		logic             departed;
		logic [GW-1:0]    dep_tag;
		logic [TW-1:0]    resp;
		logic [TW-1:0]    wait_dur;
		logic             busy;
		logic [GW-1:0]    run_tag;
		logic [TW-1:0]    finish;
		logic [CW-1:0]    count;
		srpt_pkg::err_t   err;
	} sched_report_t;

	// scheduler state as predicted; backlog kept sorted by remaining time
	srpt_pkg::job_t    backlog[$];
	logic              run_busy    = 1'b0;
	logic [TW-1:0]     run_finish  = '0;
	logic [TW-1:0]     run_size    = '0;
	logic [TW-1:0]     run_arrival = '0;
	logic [GW-1:0]     run_tag     = '0;

	sched_report_t reports_q[$];

	initial begin
		fail_count = 0;
		reports_due = 0;
	end

	function automatic logic [TW-1:0] add_sat(logic [TW-1:0] a, logic [TW-1:0] b);
		logic [TW:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[TW] ? '1 : sum[TW-1:0];
	endfunction

	function automatic logic [TW-1:0] floor_sub(logic [TW-1:0] a, logic [TW-1:0] b);
		return (a >= b) ? a - b : '0;
	endfunction

	// new job goes behind any entries with the same remaining time
	function automatic void enqueue(srpt_pkg::job_t j);
		int i;
		i = backlog.size();
		while (i > 0 && j.remain < backlog[i-1].remain)
			i--;
		backlog.insert(i, j);
	endfunction

	function automatic void launch(srpt_pkg::job_t j, logic [TW-1:0] now);
		run_busy    = 1'b1;
		run_finish  = add_sat(now, j.remain);
		run_size    = j.size;
		run_arrival = j.arrival;
		run_tag     = j.tag;
	endfunction

	function automatic sched_report_t apply_event(srpt_pkg::action_t act,
			logic [TW-1:0] now, logic [TW-1:0] size, logic [GW-1:0] tag);
		sched_report_t r;
		srpt_pkg::job_t fresh;
		srpt_pkg::job_t bumped;
		logic [TW-1:0] left;
		r = '0;
		r.err = srpt_pkg::ERR_OK;
		fresh = '{remain: size, arrival: now, size: size, tag: tag};
		if (act == srpt_pkg::ACT_ARRIVE) begin
			if (!run_busy) begin
				launch(fresh, now);
			end else if (backlog.size() >= srpt_pkg::QDEPTH) begin
				r.err = srpt_pkg::ERR_FULL;
			end else begin
				left = floor_sub(run_finish, now);
				if (left < size) begin
					enqueue(fresh);
				end else begin
					bumped = '{remain: left, arrival: run_arrival, size: run_size, tag: run_tag};
					enqueue(bumped);
					launch(fresh, now);
				end
			end
		end else if (!run_busy) begin
			r.err = srpt_pkg::ERR_IDLE;
		end else begin
			r.departed = 1'b1;
			r.dep_tag  = run_tag;
			r.resp     = floor_sub(now, run_arrival);
			r.wait_dur = floor_sub(r.resp, run_size);
			if (backlog.size() == 0) begin
				run_busy    = 1'b0;
				run_finish  = '0;
				run_size    = '0;
				run_arrival = '0;
				run_tag     = '0;
			end else begin
				launch(backlog.pop_front(), now);
			end
		end
		r.busy    = run_busy;
		r.run_tag = run_busy ? run_tag : '0;
		r.finish  = run_busy ? run_finish : '0;
		r.count   = CW'(backlog.size());
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
		if (actv !== expv) begin
			$error("%s: expected %0h, got %0h", name, expv, actv);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		sched_report_t want;
		if (arst_n) begin
			if (event_valid && !event_stall)
				reports_q.push_back(apply_event(srpt_pkg::action_t'(action), event_time,
					job_size, job_tag));
			if (result_valid && !result_stall) begin
				if (reports_q.size() == 0) begin
					$error("result item arrived with nothing expected");
					fail_count++;
				end else begin
					want = reports_q.pop_front();
					check_field("departed_valid", 32'(want.departed), 32'(departed_valid));
					check_field("departed_tag", 32'(want.dep_tag), 32'(departed_tag));
					check_field("response_time", want.resp, response_time);
					check_field("waiting_time", want.wait_dur, waiting_time);
					check_field("busy_res", 32'(want.busy), 32'(busy_res));
					check_field("running_tag", 32'(want.run_tag), 32'(running_tag));
					check_field("next_finish_time", want.finish, next_finish_time);
					check_field("waiting_count", 32'(want.count), 32'(waiting_count));
					check_field("error_code", 32'(want.err), 32'(error_code));
				end
			end
		end
		reports_due <= reports_q.size();
	end

endmodule

[tb/sv/srpt_preemptive_scheduler_test.sv]
`timescale 1ns / 1ps

module srpt_preemptive_scheduler_test;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 80;

	logic        clk;
	logic        arst_n           = 1'b0;
	logic        event_valid      = 1'b0;
	logic        event_stall;
	logic        action           = srpt_pkg::ACT_ARRIVE;
	logic [31:0] event_time       = '0;
	logic [31:0] job_size         = '0;
	logic [15:0] job_tag          = '0;
	logic        result_valid;
	logic        result_stall     = 1'b0;
	logic        departed_valid;
	logic [15:0] departed_tag;
	logic [31:0] response_time;
	logic [31:0] waiting_time;
	logic        busy_res;
	logic [15:0] running_tag;
	logic [31:0] next_finish_time;
	logic [6:0]  waiting_count;
	logic [1:0]  error_code;

	int          fail_count;
	int          reports_due;

	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	logic        hold_wanted = 1'b0;
	logic [31:0] clock_now   = '0;
	int          quiet_cycles = 0;

	srpt_preemptive_scheduler DUT (.*);

	srpt_result_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side: random stall, plus one long hold-off on request
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_wanted && !hold_done) begin
				hold_done = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((event_valid && !event_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_event(input srpt_pkg::action_t act, input logic [31:0] t,
			input logic [31:0] sz, input logic [15:0] tg);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			event_valid <= 1'b0;
			@(posedge clk);
		end
		event_valid <= 1'b1;
		action      <= act;
		event_time  <= t;
		job_size    <= sz;
		job_tag     <= tg;
		@(posedge clk);
		while (event_stall)
			@(posedge clk);
	endtask

	// stop offering and wait until every result is back
	task automatic settle();
		event_valid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0)
			@(posedge clk);
	endtask

	// mostly monotonic time with sizes near the step size, some noise
	task automatic random_event(input int done_pct);
		srpt_pkg::action_t act;
		logic [31:0]       t;
		logic [31:0]       sz;
		act = ($urandom_range(0, 99) < done_pct) ? srpt_pkg::ACT_DONE : srpt_pkg::ACT_ARRIVE;
		if ($urandom_range(0, 149) == 0)
			clock_now = 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
		else
			clock_now = clock_now + $urandom_range(0, 3000);
		t = ($urandom_range(0, 19) == 0) ? $urandom() : clock_now;
		case ($urandom_range(0, 19))
			0:       sz = '0;
			1:       sz = $urandom();
			2:       sz = 32'hFFFF_FFFF;
			3, 4, 5: sz = 32'd64 << $urandom_range(0, 2);   // ties
			default: sz = $urandom_range(1, 4000);
		endcase
		send_event(act, t, sz, 16'($urandom_range(0, 16'hFFFF)));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_event(srpt_pkg::ACT_DONE,   32'd0,  32'hFFFF_FFFF, 16'hFFFF); // idle completion
		send_event(srpt_pkg::ACT_ARRIVE, 32'd0,  32'd0, 16'h0000);
		send_event(srpt_pkg::ACT_ARRIVE, 32'd10, 32'd5, 16'hFFFF);         // remaining 0, queued
		send_event(srpt_pkg::ACT_ARRIVE, 32'd10, 32'd5, 16'h0001);         // equal, behind
		send_event(srpt_pkg::ACT_DONE,   32'd20, 32'd0, 16'h0000);
		send_event(srpt_pkg::ACT_DONE,   32'd3,  32'd0, 16'h0000);         // finish before arrival
		send_event(srpt_pkg::ACT_ARRIVE, 32'd4,  32'd100, 16'h0002);
		send_event(srpt_pkg::ACT_ARRIVE, 32'd5,  32'd3, 16'h0003);         // equal remainder preempts
		send_event(srpt_pkg::ACT_ARRIVE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'hAAAA);
		send_event(srpt_pkg::ACT_DONE,   32'hFFFF_FFF0, 32'd0, 16'h0000);
		send_event(srpt_pkg::ACT_DONE,   32'hFFFF_FFFF, 32'd0, 16'h0000);  // finish saturates
		send_event(srpt_pkg::ACT_ARRIVE, 32'hFFFF_FFFF, 32'd0, 16'h5555);
		repeat (4) send_event(srpt_pkg::ACT_DONE, 32'hFFFF_FFFF, 32'd0, 16'h0000);
		send_event(srpt_pkg::ACT_ARRIVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000);
		send_event(srpt_pkg::ACT_DONE,   32'd0, 32'hFFFF_FFFF, 16'hFFFF);
		send_event(srpt_pkg::ACT_DONE,   32'd0, 32'd0, 16'h0000);
		settle();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 6;
					rx_idle_pct = 72;
				end
				1: begin
					tx_idle_pct = 72;
					rx_idle_pct = 6;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			clock_now = $urandom_range(0, 1 << 20);
			repeat (80) random_event(45);
			if (ph == 2)
				hold_wanted <= 1'b1;
			// arrival-heavy burst overflows the queue
			repeat (90) random_event(5);
			repeat (45) random_event(85);
			settle();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
